@@ sv/pgcm_pkg.sv @@
// ============================================================================
// pgcm_pkg
// Shared types and constants of the path glob component matcher.
// ============================================================================
`default_nettype none

package pgcm_pkg;

    // Default bound on stored pattern and name bytes.
    localparam int MAX_LEN_DEFAULT = 64;

    // Special byte values.
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_DEL   = 8'h7F;

    // Input item kinds.
    localparam logic MODE_PATTERN = 1'b0;
    localparam logic MODE_NAME    = 1'b1;

    // Result status codes.
    localparam logic [1:0] STATUS_EVALUATED   = 2'd0;
    localparam logic [1:0] STATUS_NAME_LONG   = 2'd1;
    localparam logic [1:0] STATUS_BAD_BYTE    = 2'd2;
    localparam logic [1:0] STATUS_PATTERN_LONG = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic eval_init;
        logic scan_start;
        logic scan_rd;
        logic scan_step;
        logic cmp_init;
        logic cmp_rd;
        logic cmp_step;
        logic dstar_init;
        logic dstar_step;
        logic star_apply;
        logic commit_new;
        logic next_part;
        logic load_out;
        logic clear_name;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] status_code;
        logic       part_left;
        logic       scan_end;
        logic       scan_slash;
        logic       is_dstar;
        logic       is_star;
        logic       cmp_last;
        logic       dstar_last;
        logic       out_busy;
    } t_sts;

endpackage

`default_nettype wire

@@ sv/pgcm_ram.sv @@
// ============================================================================
// pgcm_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module pgcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ sv/pgcm_datapath.sv @@
// ============================================================================
// pgcm_datapath
// Byte stores, length counters, component scan and compare, match row.
// ============================================================================
`default_nettype none

module pgcm_datapath #(
    parameter int MAX_LEN = pgcm_pkg::MAX_LEN_DEFAULT
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire pgcm_pkg::t_cmd  i_cmd,
    output pgcm_pkg::t_sts       o_sts,
    input  wire logic            i_mode,
    input  wire logic [7:0]      i_byte,
    input  wire logic            i_last,
    input  wire logic            i_out_ready,
    output logic                 o_out_valid,
    output logic                 o_matched,
    output logic [1:0]           o_status
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int RW = MAX_LEN + 1;
    localparam logic [CW-1:0] LEN_MAX = CW'(MAX_LEN);

    // Ingest state.
    logic [CW-1:0]      r_plen;
    logic               r_povf;
    logic               r_pclosed;
    logic [CW-1:0]      r_nlen;
    logic               r_nlong;
    logic               r_nbad;
    logic [CW-1:0]      r_slash_cnt;
    logic               r_last_slash;
    logic [MAX_LEN-1:0] r_nonempty;

    // Evaluation state.
    logic [RW-1:0]      r_row;
    logic [RW-1:0]      r_new;
    logic [RW-1:0]      n_new;
    logic [CW-1:0]      r_nq;
    logic [CW-1:0]      r_ps;
    logic [CW-1:0]      r_sp;
    logic [1:0]         r_slen;
    logic               r_s0;
    logic               r_s1;
    logic [CW-1:0]      r_j;
    logic [CW-1:0]      r_k;
    logic [CW-1:0]      r_q;
    logic               r_eq;
    logic               r_acc;

    logic [CW-1:0]      plen_base;
    logic               p_we;
    logic               n_we;
    logic [CW-1:0]      pa;
    logic [CW-1:0]      qp1;
    logic [7:0]         pdata;
    logic [7:0]         ndata;
    logic               pat_end;
    logic               nam_end;
    logic [1:0]         status_code;

    assign plen_base = r_pclosed ? '0 : r_plen;
    assign p_we = i_cmd.accept && (i_mode == pgcm_pkg::MODE_PATTERN) && (plen_base < LEN_MAX);
    assign n_we = i_cmd.accept && (i_mode == pgcm_pkg::MODE_NAME) && (r_nlen < LEN_MAX);
    assign pa   = r_ps + r_k;
    assign qp1  = r_q + CW'(1);

    pgcm_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_pat_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (plen_base[AW-1:0]),
        .i_wdata (i_byte),
        .i_raddr (i_cmd.scan_rd ? r_sp[AW-1:0] : pa[AW-1:0]),
        .o_rdata (pdata)
    );

    pgcm_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_name_ram (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_waddr (r_nlen[AW-1:0]),
        .i_wdata (i_byte),
        .i_raddr (r_j[AW-1:0]),
        .o_rdata (ndata)
    );

    // Component end tests during the lockstep compare.
    assign pat_end = (pa == r_plen) || (pdata == pgcm_pkg::CHAR_SLASH);
    assign nam_end = (r_j == r_nlen) || (ndata == pgcm_pkg::CHAR_SLASH);

    // Status priority: pattern too long, name too long, bad byte.
    always_comb begin
        if (r_povf) begin
            status_code = pgcm_pkg::STATUS_PATTERN_LONG;
        end else if (r_nlong) begin
            status_code = pgcm_pkg::STATUS_NAME_LONG;
        end else if (r_nbad) begin
            status_code = pgcm_pkg::STATUS_BAD_BYTE;
        end else begin
            status_code = pgcm_pkg::STATUS_EVALUATED;
        end
    end

    // Next value of the row being built for an ordinary component.
    always_comb begin
        n_new = r_new;
        if (i_cmd.cmp_init) begin
            n_new = '0;
        end else if (i_cmd.cmp_step && nam_end) begin
            n_new[qp1] = r_row[r_q] && r_eq && pat_end;
        end
    end

    // Status toward the controller.
    always_comb begin
        o_sts.status_code = status_code;
        o_sts.part_left   = r_ps < r_plen;
        o_sts.scan_end    = r_sp == r_plen;
        o_sts.scan_slash  = pdata == pgcm_pkg::CHAR_SLASH;
        o_sts.is_dstar    = (r_slen == 2'd2) && r_s0 && r_s1;
        o_sts.is_star     = (r_slen == 2'd1) && r_s0;
        o_sts.cmp_last    = nam_end && ((r_j == r_nlen) ||
                            (({1'b0, r_j} + (CW + 1)'(1)) == {1'b0, r_nlen}));
        o_sts.dstar_last  = r_q == r_nq;
        o_sts.out_busy    = o_out_valid && !i_out_ready;
    end

    // Pattern and name ingest control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen       <= '0;
            r_povf       <= 1'b0;
            r_pclosed    <= 1'b0;
            r_nlen       <= '0;
            r_nlong      <= 1'b0;
            r_nbad       <= 1'b0;
            r_slash_cnt  <= '0;
            r_last_slash <= 1'b0;
            r_nonempty   <= '0;
        end else if (i_cmd.clear_name) begin
            r_nlen       <= '0;
            r_nlong      <= 1'b0;
            r_nbad       <= 1'b0;
            r_slash_cnt  <= '0;
            r_last_slash <= 1'b0;
            r_nonempty   <= '0;
        end else if (i_cmd.accept) begin
            if (i_mode == pgcm_pkg::MODE_PATTERN) begin
                r_pclosed <= i_last;
                if (plen_base < LEN_MAX) begin
                    r_plen <= plen_base + CW'(1);
                    r_povf <= r_pclosed ? 1'b0 : r_povf;
                end else begin
                    r_plen <= plen_base;
                    r_povf <= 1'b1;
                end
            end else begin
                if (r_nlen < LEN_MAX) begin
                    r_nlen <= r_nlen + CW'(1);
                    if (i_byte == pgcm_pkg::CHAR_SLASH) begin
                        r_slash_cnt  <= r_slash_cnt + CW'(1);
                        r_last_slash <= 1'b1;
                    end else begin
                        r_nonempty[r_slash_cnt[AW-1:0]] <= 1'b1;
                        r_last_slash <= 1'b0;
                    end
                end else begin
                    r_nlong <= 1'b1;
                end
                if ((i_byte < pgcm_pkg::CHAR_SPACE) || (i_byte == pgcm_pkg::CHAR_DEL)) begin
                    r_nbad <= 1'b1;
                end
            end
        end
    end

    // Evaluation datapath registers.
    always_ff @(posedge i_clk) begin
        r_new <= n_new;
        if (i_cmd.eval_init) begin
            r_row <= RW'(1);
            r_ps  <= '0;
            r_nq  <= r_slash_cnt + CW'(!r_last_slash);
        end
        if (i_cmd.scan_start) begin
            r_sp   <= r_ps;
            r_slen <= 2'd0;
            r_s0   <= 1'b0;
            r_s1   <= 1'b0;
        end
        if (i_cmd.scan_step) begin
            if (r_slen == 2'd0) begin
                r_s0 <= pdata == pgcm_pkg::CHAR_STAR;
            end
            if (r_slen == 2'd1) begin
                r_s1 <= pdata == pgcm_pkg::CHAR_STAR;
            end
            if (r_slen != 2'd3) begin
                r_slen <= r_slen + 2'd1;
            end
            r_sp <= r_sp + CW'(1);
        end
        // A lone star needs a non-empty name component.
        if (i_cmd.star_apply) begin
            r_row <= {r_row[MAX_LEN-1:0] & r_nonempty, 1'b0};
        end
        // Globstar: running OR of the row, one entry a cycle.
        if (i_cmd.dstar_init) begin
            r_q   <= '0;
            r_acc <= 1'b0;
        end
        if (i_cmd.dstar_step) begin
            r_row[r_q] <= r_acc || r_row[r_q];
            r_acc      <= r_acc || r_row[r_q];
            r_q        <= qp1;
        end
        // Lockstep byte compare of one pattern component against each name component.
        if (i_cmd.cmp_init) begin
            r_j  <= '0;
            r_k  <= '0;
            r_q  <= '0;
            r_eq <= 1'b1;
        end
        if (i_cmd.cmp_step) begin
            r_j <= r_j + CW'(1);
            if (nam_end) begin
                r_q  <= qp1;
                r_k  <= '0;
                r_eq <= 1'b1;
            end else begin
                if (pat_end || (pdata != ndata)) begin
                    r_eq <= 1'b0;
                end
                if (!pat_end) begin
                    r_k <= r_k + CW'(1);
                end
            end
        end
        if (i_cmd.commit_new) begin
            r_row <= n_new;
        end
        if (i_cmd.next_part) begin
            r_ps <= (r_sp < r_plen) ? r_sp + CW'(1) : r_sp;
        end
    end

    // Result register, held until taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_status  <= status_code;
            o_matched <= (status_code == pgcm_pkg::STATUS_EVALUATED) && r_row[r_nq];
        end
    end

endmodule

`default_nettype wire

@@ sv/pgcm_ctrl.sv @@
// ============================================================================
// pgcm_ctrl
// Sequencer for intake and the component-by-component evaluation.
// ============================================================================
`default_nettype none

module pgcm_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic            i_mode,
    input  wire logic            i_last,
    output logic                 o_ready,
    input  wire pgcm_pkg::t_sts  i_sts,
    output pgcm_pkg::t_cmd       o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_START  = 10'b0000000010,
        S_PCHK   = 10'b0000000100,
        S_SCAN_A = 10'b0000001000,
        S_SCAN_D = 10'b0000010000,
        S_KIND   = 10'b0000100000,
        S_DSTAR  = 10'b0001000000,
        S_CMP_A  = 10'b0010000000,
        S_CMP_D  = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_ready = r_state == S_IDLE;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    if ((i_mode == pgcm_pkg::MODE_NAME) && i_last) begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                if (i_sts.status_code != pgcm_pkg::STATUS_EVALUATED) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.eval_init = 1'b1;
                    n_state = S_PCHK;
                end
            end
            S_PCHK: begin
                if (i_sts.part_left) begin
                    o_cmd.scan_start = 1'b1;
                    n_state = S_SCAN_A;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCAN_A: begin
                if (i_sts.scan_end) begin
                    n_state = S_KIND;
                end else begin
                    o_cmd.scan_rd = 1'b1;
                    n_state = S_SCAN_D;
                end
            end
            S_SCAN_D: begin
                if (i_sts.scan_slash) begin
                    n_state = S_KIND;
                end else begin
                    o_cmd.scan_step = 1'b1;
                    n_state = S_SCAN_A;
                end
            end
            S_KIND: begin
                if (i_sts.is_dstar) begin
                    o_cmd.dstar_init = 1'b1;
                    n_state = S_DSTAR;
                end else if (i_sts.is_star) begin
                    o_cmd.star_apply = 1'b1;
                    o_cmd.next_part  = 1'b1;
                    n_state = S_PCHK;
                end else begin
                    o_cmd.cmp_init = 1'b1;
                    n_state = S_CMP_A;
                end
            end
            S_DSTAR: begin
                o_cmd.dstar_step = 1'b1;
                if (i_sts.dstar_last) begin
                    o_cmd.next_part = 1'b1;
                    n_state = S_PCHK;
                end
            end
            S_CMP_A: begin
                o_cmd.cmp_rd = 1'b1;
                n_state = S_CMP_D;
            end
            S_CMP_D: begin
                o_cmd.cmp_step = 1'b1;
                if (i_sts.cmp_last) begin
                    o_cmd.commit_new = 1'b1;
                    o_cmd.next_part  = 1'b1;
                    n_state = S_PCHK;
                end else begin
                    n_state = S_CMP_A;
                end
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.load_out   = 1'b1;
                    o_cmd.clear_name = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

@@ sv/path_glob_component_matcher_core.sv @@
// ============================================================================
// path_glob_component_matcher_core
// Matches streamed names against a stored slash-separated glob pattern.
// ============================================================================
// Pattern bytes (tuser 0) and name bytes (tuser 1) are taken one per cycle
// while the block is idle; a result item follows each name byte marked
// tlast. Evaluation then stops intake: for each pattern component the
// block first reads its bytes one at a time to classify it through
// the pattern store's single read port, then applies a lone star to the
// match row, sweeps a globstar across the match row, or compares an
// ordinary component byte by byte through both store read ports.
// A rejected name (too long, bad byte, or pattern too long) skips the
// evaluation. The result waits in an output register; intake resumes
// once it is loaded.
`default_nettype none

module path_glob_component_matcher_core #(
    parameter int MAX_LEN = pgcm_pkg::MAX_LEN_DEFAULT
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  wire logic [7:0] i_s_axis_tdata,   // [7:0] data_byte
    input  wire logic       i_s_axis_tuser,   // [0] mode
    input  wire logic       i_s_axis_tlast,
    output logic            o_m_axis_tvalid,
    input  wire logic       i_m_axis_tready,
    output logic [7:0]      o_m_axis_tdata    // [0] matched, [2:1] status, [7:3] zero
);

    pgcm_pkg::t_cmd cmd;
    pgcm_pkg::t_sts sts;
    logic           matched;
    logic [1:0]     status;

    pgcm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_mode  (i_s_axis_tuser),
        .i_last  (i_s_axis_tlast),
        .o_ready (o_s_axis_tready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    pgcm_datapath #(.MAX_LEN(MAX_LEN)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_mode      (i_s_axis_tuser),
        .i_byte      (i_s_axis_tdata),
        .i_last      (i_s_axis_tlast),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_matched   (matched),
        .o_status    (status)
    );

    assign o_m_axis_tdata = {5'b0, status, matched};

endmodule

`default_nettype wire

@@ test/path_glob_component_matcher_core_test.sv @@
// ============================================================================
// path_glob_component_matcher_core_test
// Self-checking bench for the path glob component matcher.
// ============================================================================
// A directed table covers stars, globstars and trailing slashes; directed
// items cover the status codes and overlong strings. Random pattern/name pairs
// follow, built mostly from a small alphabet so that matches are frequent.
// Every result item is checked against a bench predictor or a row's verdict.
`default_nettype none

module path_glob_component_matcher_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEN = 64;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_data = '0;
    logic       s_user = 1'b0;
    logic       s_last = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_data;

    path_glob_component_matcher_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata (s_data),   // [7:0] data_byte
        .i_s_axis_tuser (s_user),   // [0] mode
        .i_s_axis_tlast (s_last),
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (m_data)    // [0] matched, [2:1] status, [7:3] zero
    );

    always #5 i_clk = ~i_clk;

    // Predictor state.
    logic [7:0] pat_mem[LEN];
    int         pat_len;
    logic       pat_ovf;
    logic       pat_closed;
    logic [7:0] nam_mem[LEN];
    int         nam_len;
    logic       nam_long;
    logic       nam_bad;

    logic [7:0] verdict_queue[$];
    int         errors = 0;
    int         results_seen = 0;
    int         matches_seen = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         hold_cycles = 0;

    // Splits a stored string into component bounds.
    function automatic int split_path(input logic [7:0] s[LEN], input int len,
                                      output int st[LEN], output int en[LEN]);
        int pos;
        int n;
        int e;
        pos = 0;
        n = 0;
        while (pos < len && n < LEN) begin
            e = pos;
            while (e < len && s[e] != pgcm_pkg::CHAR_SLASH) e++;
            st[n] = pos;
            en[n] = e;
            n++;
            pos = (e < len) ? e + 1 : e;
        end
        return n;
    endfunction

    // Dynamic program over pattern components, last one first.
    function automatic logic glob_match();
        int  ps[LEN], pe[LEN], ns[LEN], ne[LEN];
        int  np;
        int  nq;
        int  pl;
        int  nl;
        logic nxt[LEN+1];
        logic cur[LEN+1];
        logic acc;
        logic eq;
        np = split_path(pat_mem, pat_len, ps, pe);
        nq = split_path(nam_mem, nam_len, ns, ne);
        for (int q = 0; q <= nq; q++) nxt[q] = (q == nq);
        for (int p = np - 1; p >= 0; p--) begin
            pl = pe[p] - ps[p];
            if (pl == 2 && pat_mem[ps[p]] == pgcm_pkg::CHAR_STAR &&
                pat_mem[ps[p]+1] == pgcm_pkg::CHAR_STAR) begin
                acc = 1'b0;
                for (int q = nq; q >= 0; q--) begin
                    acc = acc | nxt[q];
                    cur[q] = acc;
                end
            end else begin
                for (int q = 0; q <= nq; q++) begin
                    cur[q] = 1'b0;
                    if (q < nq && nxt[q+1]) begin
                        nl = ne[q] - ns[q];
                        if (pl == 1 && pat_mem[ps[p]] == pgcm_pkg::CHAR_STAR) begin
                            eq = (nl > 0);
                        end else begin
                            eq = (pl == nl);
                            for (int k = 0; k < pl && eq; k++)
                                if (pat_mem[ps[p]+k] != nam_mem[ns[q]+k]) eq = 1'b0;
                        end
                        cur[q] = eq;
                    end
                end
            end
            for (int q = 0; q <= nq; q++) nxt[q] = cur[q];
        end
        return nxt[0];
    endfunction

    // Applies one accepted input item to the predictor.
    task automatic predict_item(input logic mode, input logic [7:0] b, input logic last);
        logic [1:0] st;
        logic       hit;
        if (mode == pgcm_pkg::MODE_PATTERN) begin
            if (pat_closed) begin
                pat_len = 0;
                pat_ovf = 1'b0;
                pat_closed = 1'b0;
            end
            if (pat_len < LEN) begin
                pat_mem[pat_len] = b;
                pat_len++;
            end else begin
                pat_ovf = 1'b1;
            end
            if (last) pat_closed = 1'b1;
        end else begin
            if (nam_len < LEN) begin
                nam_mem[nam_len] = b;
                nam_len++;
            end else begin
                nam_long = 1'b1;
            end
            if (b < pgcm_pkg::CHAR_SPACE || b == pgcm_pkg::CHAR_DEL) nam_bad = 1'b1;
            if (last) begin
                hit = 1'b0;
                if (pat_ovf) st = pgcm_pkg::STATUS_PATTERN_LONG;
                else if (nam_long) st = pgcm_pkg::STATUS_NAME_LONG;
                else if (nam_bad) st = pgcm_pkg::STATUS_BAD_BYTE;
                else begin
                    st = pgcm_pkg::STATUS_EVALUATED;
                    hit = glob_match();
                end
                verdict_queue.push_back({5'b0, st, hit});
                nam_len = 0;
                nam_long = 1'b0;
                nam_bad = 1'b0;
            end
        end
    endtask

    // Drives one item, idling at random before it. Valid stays up after the
    // item is taken so that the next item can follow without a gap.
    task automatic send_item(input logic mode, input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= mode;
        s_data  <= b;
        s_last  <= last;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        predict_item(mode, b, last);
        @(negedge i_clk);
    endtask

    task automatic send_string(input logic mode, input string s);
        for (int k = 0; k < s.len(); k++) send_item(mode, s[k], k == s.len() - 1);
    endtask

    task automatic send_repeat(input logic mode, input logic [7:0] b, input int n);
        for (int k = 0; k < n; k++) send_item(mode, b, k == n - 1);
    endtask

    // Waits until every expected verdict has arrived.
    task automatic drain();
        s_valid <= 1'b0;
        while (verdict_queue.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // Receiver: random stalls plus an optional long hold-off.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready) begin
            results_seen++;
            if (verdict_queue.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result item %h", m_data);
            end else begin
                if (m_data !== verdict_queue[0]) begin
                    errors++;
                    if (errors <= 10)
                        $display("result %0d: expected status %0d matched %0d, got %h",
                                 results_seen, verdict_queue[0][2:1], verdict_queue[0][0],
                                 m_data);
                end
                if (m_data[0] === 1'b1) matches_seen++;
                void'(verdict_queue.pop_front());
            end
        end
    end

    // Directed rows: pattern, name, expected verdict (-1 means use predictor).
    typedef struct {
        string pat;
        string nam;
        int    verdict;
    } t_row;

    // An empty pattern string leaves the stored pattern as it is.
    t_row rows[] = '{
        '{"", "a", 0},
        '{"a/b", "a/b", 1},
        '{"", "a/b/", 1},
        '{"*", "abc", -1},
        '{"*", "/", -1},
        '{"a/*", "a/", -1},
        '{"**", "x/y/z", -1},
        '{"a/**/z", "a/z", -1},
        '{"a/**/z", "a/b/c/z", -1},
        '{"a/**", "a", -1},
        '{"a/", "a", -1},
        '{"a//b", "a//b", -1},
        '{"**/**", "q", -1},
        '{"a*", "ab", -1},
        '{"~ ", "~ ", -1}
    };

    // Random component from a small alphabet.
    function automatic string rand_part();
        string s;
        int    n;
        s = "";
        case ($urandom_range(7))
            0: s = "*";
            1: s = "**";
            default: begin
                n = $urandom_range(3);
                for (int k = 0; k < n; k++)
                    s = {s, string'(8'(32'h61 + $urandom_range(2)))};
            end
        endcase
        return s;
    endfunction

    function automatic string rand_path(input bit globs);
        string s;
        string c;
        int    n;
        n = $urandom_range(1, 4);
        s = "";
        for (int k = 0; k < n; k++) begin
            c = rand_part();
            if (!globs && (c == "*" || c == "**")) c = "b";
            s = (k == 0) ? c : {s, "/", c};
        end
        if ($urandom_range(5) == 0) s = {s, "/"};
        if (s.len() == 0) s = "a";
        return s;
    endfunction

    // Main stimulus.
    initial begin
        int items;
        int phase;
        string p;
        string n;
        pat_len = 0; pat_ovf = 0; pat_closed = 0;
        nam_len = 0; nam_long = 0; nam_bad = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table.
        foreach (rows[r]) begin
            if (rows[r].pat.len() > 0) send_string(pgcm_pkg::MODE_PATTERN, rows[r].pat);
            send_string(pgcm_pkg::MODE_NAME, rows[r].nam);
            if (rows[r].verdict >= 0 && verdict_queue.size() > 0)
                verdict_queue[$] = {5'b0, pgcm_pkg::STATUS_EVALUATED, rows[r].verdict[0]};
        end
        // Bad bytes, extremes, overlong strings, and their priority.
        send_item(pgcm_pkg::MODE_NAME, 8'h00, 1'b1);
        send_item(pgcm_pkg::MODE_NAME, 8'h7F, 1'b1);
        send_item(pgcm_pkg::MODE_NAME, 8'hFF, 1'b1);
        send_item(pgcm_pkg::MODE_NAME, 8'h1F, 1'b1);
        send_repeat(pgcm_pkg::MODE_NAME, 8'h61, LEN);
        send_repeat(pgcm_pkg::MODE_NAME, 8'h61, LEN + 1);
        send_item(pgcm_pkg::MODE_NAME, 8'h00, 1'b0);
        send_repeat(pgcm_pkg::MODE_NAME, 8'h61, LEN + 1);
        // Partial pattern, then an overlong one.
        send_item(pgcm_pkg::MODE_PATTERN, 8'h61, 1'b0);
        send_item(pgcm_pkg::MODE_NAME, 8'h61, 1'b1);
        send_item(pgcm_pkg::MODE_PATTERN, 8'h61, 1'b1);
        send_repeat(pgcm_pkg::MODE_PATTERN, 8'h61, LEN + 2);
        send_item(pgcm_pkg::MODE_NAME, 8'h61, 1'b1);
        send_item(pgcm_pkg::MODE_NAME, 8'h00, 1'b1);
        send_string(pgcm_pkg::MODE_PATTERN, "a");
        drain();

        // Long receiver hold-off while items keep coming.
        hold_cycles = 300;
        for (int k = 0; k < 6; k++) send_string(pgcm_pkg::MODE_NAME, "a");
        drain();

        // Random phases.
        items = 0;
        phase = 0;
        while (items < 680) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            for (int t = 0; t < 15; t++) begin
                if ($urandom_range(3) == 0) begin
                    p = rand_path(1'b1);
                    send_string(pgcm_pkg::MODE_PATTERN, p);
                    items += p.len();
                end
                if ($urandom_range(9) == 0) begin
                    // Noise: fully random bytes.
                    for (int k = $urandom_range(1, 6); k > 0; k--) begin
                        send_item(pgcm_pkg::MODE_NAME, 8'($urandom), k == 1);
                        items++;
                    end
                end else begin
                    n = rand_path(1'b0);
                    send_string(pgcm_pkg::MODE_NAME, n);
                    items += n.len();
                end
            end
            if (phase % 4 == 3) drain();
            phase++;
        end
        // Random pattern byte bits too.
        for (int k = 0; k < 8; k++) send_item(pgcm_pkg::MODE_PATTERN, 8'($urandom), k == 7);
        send_item(pgcm_pkg::MODE_NAME, 8'h80, 1'b1);
        drain();

        $display("Ran %0d results (%0d matches) over directed cases and random paths,",
                 results_seen, matches_seen);
        $display("with idle, stall and hold-off phases on both sides.");
        if (errors == 0 && verdict_queue.size() == 0) begin
            $display("path_glob_component_matcher_core: match");
        end else begin
            $display("path_glob_component_matcher_core: mismatch");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #20ms;
        $display("path_glob_component_matcher_core: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
